/* hw/rtl/rrlb_pkg.sv */
// shared constants, types and helpers for the receive line buffer
`timescale 1ns / 1ps

package rrlb_pkg;

    // ring geometry
    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    // counter wide enough to hold DEPTH itself
    localparam int CNT_W = IDX_W + 1;
    // common width for comparing counts against the 8-bit limit
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    // operation codes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // one result as handed from the sequencer to the output stage
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic       found;
        logic [5:0] count;
    } res_t;

    // ring index increment with wrap
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(DEPTH - 1))
            r = '0;
        else
            r = i + 1'b1;
        return r;
    endfunction

endpackage

/* hw/rtl/rrlb_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module rrlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/rrlb_ctrl.sv */
// sequencer: ring indices, entry walk and shared delimiter compare
`timescale 1ns / 1ps

module rrlb_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [1:0]                opcode,
    input  logic [7:0]                rx_byte,
    input  logic [7:0]                read_limit,
    input  logic [7:0]                eol_char,
    output logic                      busy,
    output logic                      ram_we,
    output logic [rrlb_pkg::IDX_W-1:0] ram_waddr,
    output logic [7:0]                ram_wdata,
    output logic [rrlb_pkg::IDX_W-1:0] ram_raddr,
    input  logic [7:0]                ram_rdata,
    output rrlb_pkg::res_t            res
);

    import rrlb_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_QUERY = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [7:0]       eol_reg, eol_next;
    logic [7:0]       limit_reg, limit_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             accept;
    logic             ring_empty;
    logic             limit_bad;
    logic             eol_hit;
    logic             at_limit;
    logic [CNT_W-1:0] count_inc;

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign ring_empty = (head_reg == tail_reg);
    assign limit_bad  = (read_limit == 8'd0) || (CMP_W'(read_limit) > CMP_W'(DEPTH));
    // the one compare unit, shared by query and read walks
    assign eol_hit    = (ram_rdata == eol_reg);
    assign count_inc  = count_reg + 1'b1;
    assign at_limit   = (CMP_W'(count_inc) == CMP_W'(limit_reg));

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        ptr_next   = ptr_reg;
        eol_next   = eol_reg;
        limit_next = limit_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        ram_waddr  = tail_reg;
        ram_wdata  = rx_byte;
        ram_raddr  = ptr_reg;
        res        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // prefetch the oldest entry so a walk can start next cycle
                ram_raddr = head_reg;
                if (accept)
                begin
                    case (opcode)
                        OP_PUSH:
                        begin
                            ram_we    = 1'b1;
                            tail_next = next_idx(tail_reg);
                            if (next_idx(tail_reg) == head_reg)
                            begin
                                head_next = next_idx(head_reg);
                            end
                        end
                        OP_QUERY:
                        begin
                            eol_next = eol_char;
                            if (ring_empty)
                            begin
                                res.valid = 1'b1;
                                res.kind  = KIND_QUERY;
                                res.last  = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = next_idx(head_reg);
                                state_next = ST_QUERY;
                            end
                        end
                        OP_READ:
                        begin
                            if (limit_bad || ring_empty)
                            begin
                                res.valid = 1'b1;
                                res.kind  = KIND_EMPTY;
                                res.last  = 1'b1;
                            end
                            else
                            begin
                                eol_next   = eol_char;
                                limit_next = read_limit;
                                count_next = '0;
                                ptr_next   = next_idx(head_reg);
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_QUERY:
            begin
                // ram data holds the entry just before ptr
                if (eol_hit || (ptr_reg == tail_reg))
                begin
                    res.valid  = 1'b1;
                    res.kind   = KIND_QUERY;
                    res.last   = 1'b1;
                    res.found  = eol_hit;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = next_idx(ptr_reg);
                end
            end
            ST_READ:
            begin
                // pop the entry at head, which ram data holds
                res.valid  = 1'b1;
                res.kind   = KIND_DATA;
                res.data   = ram_rdata;
                head_next  = ptr_reg;
                count_next = count_inc;
                if (eol_hit || (ptr_reg == tail_reg) || at_limit)
                begin
                    res.last   = 1'b1;
                    res.count  = 6'(count_inc);
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = next_idx(ptr_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        eol_reg   <= eol_next;
        limit_reg <= limit_next;
        count_reg <= count_next;
    end

    // a push leaves the sequencer idle and the ring non-empty in the next cycle
    a_push_single: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (opcode == OP_PUSH) |=> !busy && (head_reg != tail_reg))
        else $error("push did not complete in one cycle");

    // the final result of an item returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.last |=> (state_reg == ST_IDLE))
        else $error("sequencer busy after final result");

    // only data bytes of a read may be followed by more results
    a_not_last_data: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.last |-> (res.kind == KIND_DATA) && (state_reg == ST_READ))
        else $error("non-final result outside a read walk");

    // a read walk never runs in an empty ring
    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (head_reg != tail_reg))
        else $error("read walk on empty ring");

endmodule

/* hw/rtl/rx_ring_line_buffer.sv */
// top level of the receive ring line buffer: sequencer, byte ram, result register
`timescale 1ns / 1ps

// channel   | handshake               | payload
// ----------+-------------------------+---------------------------------------------
// command   | start high, busy low    | opcode, rx_byte, read_limit, eol_char
// result    | result_valid, one cycle | result_kind, data_byte, is_last, delim_seen,
//           |                         | bytes_read
//
// a push leaves busy low
// a query examines entries from head until a delimiter (up to the fill level)
// a read pops bytes up to a delimiter or the limit; the single ram read port sets
// the pace of one entry per cycle
// every result leaves through a register, in the cycle after it is formed
// asynchronous active-low reset empties the ring; the receiver cannot stall

module rx_ring_line_buffer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] opcode,
    input  logic [7:0] rx_byte,
    input  logic [7:0] read_limit,
    input  logic [7:0] eol_char,
    output logic       result_valid,
    output logic [1:0] result_kind,
    output logic [7:0] data_byte,
    output logic       is_last,
    output logic       delim_seen,
    output logic [5:0] bytes_read
);

    import rrlb_pkg::*;

    // ram hookup
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    // result from the sequencer, before the output register
    res_t res;

    // output register: strobe is control, fields are payload
    logic       result_valid_reg;
    logic [1:0] result_kind_reg;
    logic [7:0] data_byte_reg;
    logic       is_last_reg;
    logic       delim_seen_reg;
    logic [5:0] bytes_read_reg;

    rrlb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .opcode     (opcode),
        .rx_byte    (rx_byte),
        .read_limit (read_limit),
        .eol_char   (eol_char),
        .busy       (busy),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .res        (res)
    );

    // byte store, never cleared: only entries between head and tail are read
    rrlb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // the strobe lasts exactly one cycle per result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= res.valid;
        end
    end

    // payload only loads when a result is formed
    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            result_kind_reg <= res.kind;
            data_byte_reg   <= res.data;
            is_last_reg     <= res.last;
            delim_seen_reg  <= res.found;
            bytes_read_reg  <= res.count;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_kind  = result_kind_reg;
    assign data_byte    = data_byte_reg;
    assign is_last      = is_last_reg;
    assign delim_seen   = delim_seen_reg;
    assign bytes_read   = bytes_read_reg;

endmodule
